@@ rtl/csvtok_pkg.sv @@
// Shared types, codes and the per-byte field tokenizer step for the CSV tokenizer.
package csvtok_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // Field tokenizer states
    localparam logic [1:0] FS_START  = 2'd0;
    localparam logic [1:0] FS_PLAIN  = 2'd1;
    localparam logic [1:0] FS_QUOTED = 2'd2;
    localparam logic [1:0] FS_QSEEN  = 2'd3;

    // Special bytes
    localparam logic [7:0] MARK0   = 8'hEF;
    localparam logic [7:0] MARK1   = 8'hBB;
    localparam logic [7:0] MARK2   = 8'hBF;
    localparam logic [7:0] QUOTE   = 8'h22;
    localparam logic [7:0] COMMA   = 8'h2C;
    localparam logic [7:0] NEWLINE = 8'h0A;

    localparam int unsigned MAX_TOKENS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] content;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] content;
    } tok_t;

    // All tokens caused by one input byte, in order, slot 0 first
    typedef struct packed {
        logic [1:0]                  cnt;
        tok_t [MAX_TOKENS-1:0]       toks;
    } bundle_t;

    typedef struct packed {
        logic [1:0] next_state;
        logic       emit;
        tok_t       tok;
    } tok_step_t;

    function automatic tok_step_t tokenize(input logic [1:0] st, input logic [7:0] b);
        tok_step_t r;
        r.next_state  = st;
        r.emit        = 1'b1;
        r.tok.kind    = KIND_CONTENT;
        r.tok.content = b;
        case (st)
            FS_START: begin
                if (b == QUOTE) begin
                    r.next_state = FS_QUOTED;
                    r.emit       = 1'b0;
                end else if (b == COMMA) begin
                    r.tok.kind = KIND_FIELD_END;
                end else if (b == NEWLINE) begin
                    r.tok.kind = KIND_ROW_END;
                end else begin
                    r.next_state = FS_PLAIN;
                end
            end
            FS_PLAIN: begin
                if (b == COMMA) begin
                    r.next_state = FS_START;
                    r.tok.kind   = KIND_FIELD_END;
                end else if (b == NEWLINE) begin
                    r.next_state = FS_START;
                    r.tok.kind   = KIND_ROW_END;
                end
            end
            FS_QUOTED: begin
                if (b == QUOTE) begin
                    r.next_state = FS_QSEEN;
                    r.emit       = 1'b0;
                end
            end
            default: begin
                if (b == QUOTE) begin
                    r.next_state = FS_QUOTED;
                end else if (b == COMMA) begin
                    r.next_state = FS_START;
                    r.tok.kind   = KIND_FIELD_END;
                end else if (b == NEWLINE) begin
                    r.next_state = FS_START;
                    r.tok.kind   = KIND_ROW_END;
                end else begin
                    r.next_state = FS_PLAIN;
                end
            end
        endcase
        if (r.tok.kind != KIND_CONTENT) begin
            r.tok.content = 8'd0;
        end
        return r;
    endfunction

endpackage

@@ rtl/csv_field_tokenizer_core.sv @@
// Top level of the streaming CSV field tokenizer: front end, bundle queue, back end.
// Path: with nothing queued ahead, the first result of a byte taken on s_ passes
// through the queue write and then the output register load before it is valid on m_.
// Throughput: one byte per cycle while m_ready is high and each byte yields at most one
// result; a byte with more results keeps the output busy longer, absorbed by the queue.
// Reset: synchronous active-low aresetn clears field state, mark check, queue and output.
module csv_field_tokenizer_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  csvtok_pkg::in_t     s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output csvtok_pkg::out_t    m_data
);

    logic                in_fire;
    logic                push;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    csvtok_pkg::bundle_t bundle;
    csvtok_pkg::bundle_t q_head;

    // Take a request whenever the queue has room; bytes with no result push nothing
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    // Mark check and tokenizing: every result of one byte in a single bundle
    csvtok_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_data (s_data),
        .push    (push),
        .bundle  (bundle)
    );

    // Decouple the front end from output stalls
    csvtok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (bundle),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Drain bundles one result per cycle while m_ready allows, flag the final result of each byte
    csvtok_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/csvtok_front.sv @@
// Front end: byte order mark check, field tokenizing and bundling of results per byte.
module csvtok_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  csvtok_pkg::in_t    in_data,
    output logic               push,
    output csvtok_pkg::bundle_t bundle
);

    localparam logic [1:0] MC_EXPECT0 = 2'd0;
    localparam logic [1:0] MC_GOT0    = 2'd1;
    localparam logic [1:0] MC_GOT1    = 2'd2;
    localparam logic [1:0] MC_DONE    = 2'd3;

    logic [1:0] field_state_reg, field_state_next;
    logic [1:0] mark_reg, mark_next;

    logic [1:0] mc_eff;
    logic       absorbed;
    logic       flush;
    logic [7:0] b;

    csvtok_pkg::tok_step_t st0, st1, st2;
    logic [1:0] fs_a, fs_b;
    logic       en0, en1, en2;

    always_comb begin
        b      = in_data.in_byte;
        mc_eff = in_data.stream_start ? MC_EXPECT0 : mark_reg;
        absorbed = ((mc_eff == MC_EXPECT0) && (b == csvtok_pkg::MARK0)) ||
                   ((mc_eff == MC_GOT0)    && (b == csvtok_pkg::MARK1)) ||
                   ((mc_eff == MC_GOT1)    && (b == csvtok_pkg::MARK2));
        // release held mark bytes on a new stream or on a mismatch
        flush = in_data.stream_start ||
                (((mc_eff == MC_GOT0) || (mc_eff == MC_GOT1)) && !absorbed);
        en0 = flush && ((mark_reg == MC_GOT0) || (mark_reg == MC_GOT1));
        en1 = flush && (mark_reg == MC_GOT1);
        en2 = !absorbed;

        st0  = csvtok_pkg::tokenize(field_state_reg, csvtok_pkg::MARK0);
        fs_a = en0 ? st0.next_state : field_state_reg;
        st1  = csvtok_pkg::tokenize(fs_a, csvtok_pkg::MARK1);
        fs_b = en1 ? st1.next_state : fs_a;
        st2  = csvtok_pkg::tokenize(fs_b, b);
        field_state_next = en2 ? st2.next_state : fs_b;
        mark_next = absorbed ? (mc_eff + 2'd1) : MC_DONE;
    end

    // Pack emitted tokens into consecutive slots
    always_comb begin
        bundle = '0;
        if (en0 && st0.emit) begin
            bundle.toks[bundle.cnt] = st0.tok;
            bundle.cnt = bundle.cnt + 2'd1;
        end
        if (en1 && st1.emit) begin
            bundle.toks[bundle.cnt] = st1.tok;
            bundle.cnt = bundle.cnt + 2'd1;
        end
        if (en2 && st2.emit) begin
            bundle.toks[bundle.cnt] = st2.tok;
            bundle.cnt = bundle.cnt + 2'd1;
        end
        push = in_fire && (bundle.cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_state_reg <= csvtok_pkg::FS_START;
            mark_reg        <= MC_EXPECT0;
        end else if (in_fire) begin
            field_state_reg <= field_state_next;
            mark_reg        <= mark_next;
        end
    end

endmodule

@@ rtl/csvtok_queue.sv @@
// Small FIFO of result bundles between front end and back end.
module csvtok_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  csvtok_pkg::bundle_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output csvtok_pkg::bundle_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    csvtok_pkg::bundle_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/csvtok_back.sv @@
// Back end: serializes queued bundles onto the result channel through an output register.
module csvtok_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  csvtok_pkg::bundle_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output csvtok_pkg::out_t    m_data
);

    logic             m_valid_reg;
    csvtok_pkg::out_t m_data_reg;
    logic [1:0]       idx_reg;
    logic             load;
    logic             is_last;

    assign load    = !m_valid_reg || m_ready;
    assign is_last = (idx_reg == (q_head.cnt - 2'd1));
    assign q_pop   = load && !q_empty && is_last;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load && !q_empty) begin
            m_data_reg.kind    <= q_head.toks[idx_reg].kind;
            m_data_reg.content <= q_head.toks[idx_reg].content;
            m_data_reg.last    <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else if (load) begin
            m_valid_reg <= !q_empty;
            if (!q_empty) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

endmodule
